// ===== rtl/core/plc_pkg.sv =====
// Shared constants and codes for the piecewise linear curve lookup core.
package plc_pkg;

   // Table geometry.
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = CNT_W + 1;

   // Field widths.
   localparam int X_W = 16;
   localparam int Y_W = 16;

   // One divider stage per quotient bit; the quotient never exceeds |y1 - y0|.
   localparam int DIV_STAGES = Y_W;

   // Word kinds on the request channel.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

endpackage

// ===== rtl/core/piecewise_linear_curve_lookup_core.sv =====
// Piecewise linear curve lookup: breakpoint table, segment search and pipelined divide.
// Throughput: one word per cycle; busy stays low and results cannot be held off.
// An evaluate word passes through the request register, one search stage, one multiply stage,
// 16 divider stages and the result register.
// Reset clears the pipeline valid bits and points_in_use; the table is undefined until loaded.
module piecewise_linear_curve_lookup_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [plc_pkg::IDX_W-1:0]     req_point_index,
   input  logic [plc_pkg::X_W-1:0]       req_point_x,
   input  logic signed [plc_pkg::Y_W-1:0] req_point_y,
   input  logic [plc_pkg::X_W-1:0]       req_query_x,
   output logic                          rsp_valid,
   output logic signed [plc_pkg::Y_W-1:0] rsp_curve_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [plc_pkg::CNT_W-1:0]     csr_points_in_use
);

   localparam int DS = plc_pkg::DIV_STAGES;

   // The pipeline never stalls.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration register.
   logic [plc_pkg::CNT_W-1:0] cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= csr_points_in_use;
      end
   end

   // Stage 1: request word register.
   logic                      s1_valid_ff;
   logic                      s1_kind_ff;
   logic [plc_pkg::IDX_W-1:0] s1_index_ff;
   logic [plc_pkg::X_W-1:0]   s1_px_ff;
   logic signed [plc_pkg::Y_W-1:0] s1_py_ff;
   logic [plc_pkg::X_W-1:0]   s1_query_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_kind_ff  <= req_kind;
      s1_index_ff <= req_point_index;
      s1_px_ff    <= req_point_x;
      s1_py_ff    <= req_point_y;
      s1_query_ff <= req_query_x;
   end

   // Breakpoint table; loads land here in word order ahead of later evaluates.
   logic [plc_pkg::X_W-1:0]        tab_x_ff [plc_pkg::DEPTH];
   logic signed [plc_pkg::Y_W-1:0] tab_y_ff [plc_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_kind_ff == plc_pkg::KIND_LOAD &&
          {1'b0, s1_index_ff} < plc_pkg::CNT_W'(plc_pkg::DEPTH)) begin
         tab_x_ff[s1_index_ff] <= s1_px_ff;
         tab_y_ff[s1_index_ff] <= s1_py_ff;
      end
   end

   // Segment search against the whole table and the end-point cases.
   logic [plc_pkg::CNT_W-1:0] n_cnt;
   logic [plc_pkg::CNT_W-1:0] last_cnt;
   logic [plc_pkg::IDX_W-1:0] last_idx;
   logic [plc_pkg::IDX_W-1:0] sel_idx;
   logic [plc_pkg::IDX_W-1:0] prv_idx;
   logic                      a_direct;
   logic signed [plc_pkg::Y_W-1:0] a_dval;

   always_comb begin
      n_cnt = (cfg_ff > plc_pkg::CNT_W'(plc_pkg::DEPTH)) ?
              plc_pkg::CNT_W'(plc_pkg::DEPTH) : cfg_ff;
      last_cnt = n_cnt - plc_pkg::CNT_W'(1);
      last_idx = last_cnt[plc_pkg::IDX_W-1:0];
      sel_idx  = last_idx;
      for (int k = plc_pkg::DEPTH - 1; k >= 1; k--) begin
         if (tab_x_ff[k] > s1_query_ff &&
             (plc_pkg::CMP_W'(k) + plc_pkg::CMP_W'(2)) <= {1'b0, n_cnt}) begin
            sel_idx = plc_pkg::IDX_W'(k);
         end
      end
      prv_idx = sel_idx - plc_pkg::IDX_W'(1);
      a_direct = 1'b1;
      a_dval   = '0;
      if (n_cnt == '0) begin
         a_dval = '0;
      end else if (s1_query_ff <= tab_x_ff[0]) begin
         a_dval = tab_y_ff[0];
      end else if (s1_query_ff >= tab_x_ff[last_idx]) begin
         a_dval = tab_y_ff[last_idx];
      end else begin
         a_direct = 1'b0;
      end
   end

   // Stage 2: selected segment.
   logic                      s2_valid_ff;
   logic                      s2_direct_ff;
   logic signed [plc_pkg::Y_W-1:0] s2_dval_ff;
   logic [plc_pkg::X_W-1:0]   s2_query_ff;
   logic [plc_pkg::X_W-1:0]   s2_x0_ff;
   logic [plc_pkg::X_W-1:0]   s2_x1_ff;
   logic signed [plc_pkg::Y_W-1:0] s2_y0_ff;
   logic signed [plc_pkg::Y_W-1:0] s2_y1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_kind_ff == plc_pkg::KIND_EVAL;
      end
      s2_direct_ff <= a_direct;
      s2_dval_ff   <= a_dval;
      s2_query_ff  <= s1_query_ff;
      s2_x0_ff     <= tab_x_ff[prv_idx];
      s2_x1_ff     <= tab_x_ff[sel_idx];
      s2_y0_ff     <= tab_y_ff[prv_idx];
      s2_y1_ff     <= tab_y_ff[sel_idx];
   end

   // Offset, span and rise of the segment, then the magnitude product.
   logic [plc_pkg::X_W-1:0]          b_dq;
   logic [plc_pkg::X_W-1:0]          b_dx;
   logic signed [plc_pkg::Y_W:0]     b_dy;
   logic [plc_pkg::Y_W:0]            b_mag;
   logic [plc_pkg::X_W+plc_pkg::Y_W:0] b_prod;

   always_comb begin
      b_dq   = s2_query_ff - s2_x0_ff;
      b_dx   = s2_x1_ff - s2_x0_ff;
      b_dy   = (plc_pkg::Y_W+1)'(s2_y1_ff) - (plc_pkg::Y_W+1)'(s2_y0_ff);
      b_mag  = b_dy[plc_pkg::Y_W] ? unsigned'(-b_dy) : unsigned'(b_dy);
      b_prod = (plc_pkg::X_W+plc_pkg::Y_W+1)'(b_dq) *
               (plc_pkg::X_W+plc_pkg::Y_W+1)'(b_mag);
   end

   // Stage 3: product register.
   logic                      s3_valid_ff;
   logic                      s3_direct_ff;
   logic signed [plc_pkg::Y_W-1:0] s3_dval_ff;
   logic signed [plc_pkg::Y_W-1:0] s3_y0_ff;
   logic                      s3_neg_ff;
   logic [plc_pkg::X_W-1:0]   s3_dx_ff;
   logic [plc_pkg::X_W+plc_pkg::Y_W-1:0] s3_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      // A zero span falls back to the left ordinate.
      s3_direct_ff <= s2_direct_ff || (b_dx == '0);
      s3_dval_ff   <= s2_direct_ff ? s2_dval_ff : s2_y0_ff;
      s3_y0_ff     <= s2_y0_ff;
      s3_neg_ff    <= b_dy[plc_pkg::Y_W];
      s3_dx_ff     <= b_dx;
      s3_num_ff    <= b_prod[plc_pkg::X_W+plc_pkg::Y_W-1:0];
   end

   // Divider pipeline: one restoring step per stage, quotient shifts in behind the dividend.
   logic                      d_valid_ff [DS];
   logic                      d_direct_ff [DS];
   logic signed [plc_pkg::Y_W-1:0] d_dval_ff [DS];
   logic signed [plc_pkg::Y_W-1:0] d_y0_ff [DS];
   logic                      d_neg_ff [DS];
   logic [plc_pkg::X_W-1:0]   d_dx_ff [DS];
   logic [plc_pkg::X_W-1:0]   d_rem_ff [DS];
   logic [plc_pkg::Y_W-1:0]   d_bits_ff [DS];

   logic [plc_pkg::X_W-1:0]   d_rem_src [DS];
   logic [plc_pkg::Y_W-1:0]   d_bits_src [DS];
   logic [plc_pkg::X_W-1:0]   d_dx_src [DS];
   logic [plc_pkg::X_W:0]     d_trial [DS];
   logic [plc_pkg::X_W-1:0]   d_rem_in [DS];
   logic [plc_pkg::Y_W-1:0]   d_bits_in [DS];

   always_comb begin
      for (int j = 0; j < DS; j++) begin
         if (j == 0) begin
            d_rem_src[j]  = s3_num_ff[plc_pkg::X_W+plc_pkg::Y_W-1:plc_pkg::Y_W];
            d_bits_src[j] = s3_num_ff[plc_pkg::Y_W-1:0];
            d_dx_src[j]   = s3_dx_ff;
         end else begin
            d_rem_src[j]  = d_rem_ff[j-1];
            d_bits_src[j] = d_bits_ff[j-1];
            d_dx_src[j]   = d_dx_ff[j-1];
         end
         d_trial[j] = {d_rem_src[j], d_bits_src[j][plc_pkg::Y_W-1]};
         if (d_trial[j] >= {1'b0, d_dx_src[j]}) begin
            d_rem_in[j]  = plc_pkg::X_W'(d_trial[j] - {1'b0, d_dx_src[j]});
            d_bits_in[j] = {d_bits_src[j][plc_pkg::Y_W-2:0], 1'b1};
         end else begin
            d_rem_in[j]  = d_trial[j][plc_pkg::X_W-1:0];
            d_bits_in[j] = {d_bits_src[j][plc_pkg::Y_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DS; j++) begin
         if (reset) begin
            d_valid_ff[j] <= 1'b0;
         end else if (j == 0) begin
            d_valid_ff[j] <= s3_valid_ff;
         end else begin
            d_valid_ff[j] <= d_valid_ff[j-1];
         end
         if (j == 0) begin
            d_direct_ff[j] <= s3_direct_ff;
            d_dval_ff[j]   <= s3_dval_ff;
            d_y0_ff[j]     <= s3_y0_ff;
            d_neg_ff[j]    <= s3_neg_ff;
         end else begin
            d_direct_ff[j] <= d_direct_ff[j-1];
            d_dval_ff[j]   <= d_dval_ff[j-1];
            d_y0_ff[j]     <= d_y0_ff[j-1];
            d_neg_ff[j]    <= d_neg_ff[j-1];
         end
         d_dx_ff[j]   <= d_dx_src[j];
         d_rem_ff[j]  <= d_rem_in[j];
         d_bits_ff[j] <= d_bits_in[j];
      end
   end

   // Signed term, sum with the left ordinate and saturation.
   logic signed [plc_pkg::Y_W+1:0] e_term;
   logic signed [plc_pkg::Y_W+1:0] e_sum;
   logic signed [plc_pkg::Y_W-1:0] e_value;

   always_comb begin
      e_term = signed'({2'b00, d_bits_ff[DS-1]});
      if (d_neg_ff[DS-1]) begin
         e_term = -e_term;
      end
      e_sum = (plc_pkg::Y_W+2)'(d_y0_ff[DS-1]) + e_term;
      if (e_sum > (plc_pkg::Y_W+2)'(32767)) begin
         e_value = 16'sh7fff;
      end else if (e_sum < -(plc_pkg::Y_W+2)'(32768)) begin
         e_value = -16'sh8000;
      end else begin
         e_value = e_sum[plc_pkg::Y_W-1:0];
      end
      if (d_direct_ff[DS-1]) begin
         e_value = d_dval_ff[DS-1];
      end
   end

   // Result register.
   logic                      rsp_valid_ff;
   logic signed [plc_pkg::Y_W-1:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d_valid_ff[DS-1];
      end
      rsp_value_ff <= e_value;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = rsp_value_ff;

endmodule

// ===== rtl/core/plc_checker.sv =====
// Port-level checks for the curve lookup core, bound to the top level.
module plc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_kind,
   input logic                          rsp_valid
);

   // A cleared pipeline shows no result.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // Every evaluate word yields a result.
   a_eval_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == plc_pkg::KIND_EVAL) |-> ##20 rsp_valid)
      else $error("evaluate word lost its result");

   // A load word yields no result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == plc_pkg::KIND_LOAD) |-> ##20 !rsp_valid)
      else $error("load word produced a result");

   // An empty slot yields no result.
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##20 !rsp_valid)
      else $error("result without a word");

endmodule

bind piecewise_linear_curve_lookup_core plc_checker u_plc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the piecewise linear curve lookup core.
`timescale 1ns / 100ps

module tb_top;
   import plc_pkg::*;

   // One request word as the driver presents it.
   typedef struct {
      logic                  kind;
      logic [IDX_W-1:0]      slot;
      logic [X_W-1:0]        px;
      logic signed [Y_W-1:0] py;
      logic [X_W-1:0]        qx;
   } curve_word_type;

   localparam int LATENCY     = 20;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = KIND_LOAD;
   logic [IDX_W-1:0]      req_point_index = '0;
   logic [X_W-1:0]        req_point_x = '0;
   logic signed [Y_W-1:0] req_point_y = '0;
   logic [X_W-1:0]        req_query_x = '0;
   logic                  rsp_valid;
   logic signed [Y_W-1:0] rsp_curve_value;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_points_in_use = '0;

   piecewise_linear_curve_lookup_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_point_index(req_point_index),
      .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_query_x(req_query_x), .rsp_valid(rsp_valid),
      .rsp_curve_value(rsp_curve_value), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_points_in_use(csr_points_in_use)
   );

   // Shadow of the breakpoint table and of the point count, as the block sees them.
   logic [X_W-1:0]        shadow_x [DEPTH];
   logic signed [Y_W-1:0] shadow_y [DEPTH];
   int                    shadow_count = 0;

   curve_word_type        pending_words [$];
   logic signed [Y_W-1:0] expected_values [$];
   int                    mismatch_count = 0;
   int                    unmatched_count = 0;
   int                    gap_left = 0;
   bit                    burst_mode = 1'b0;
   bit                    fire;
   int                    cycle_count = 0;

   // Breakpoints as generated, used only to aim queries.
   logic [X_W-1:0]        plan_x [DEPTH];
   int                    words_queued = 0;

   // Interpolated curve value at query q from the shadow table.
   function automatic logic signed [Y_W-1:0] interpolate_curve(logic [X_W-1:0] q);
      int     n;
      int     i;
      int     dx;
      longint num;
      longint sum;
      n = (shadow_count > DEPTH) ? DEPTH : shadow_count;
      if (n == 0) return '0;
      if (q <= shadow_x[0]) return shadow_y[0];
      if (q >= shadow_x[n-1]) return shadow_y[n-1];
      i = 1;
      while (i < n - 1 && shadow_x[i] <= q) i++;
      dx = int'(shadow_x[i]) - int'(shadow_x[i-1]);
      if (dx <= 0) return shadow_y[i-1];
      num = longint'(int'(q) - int'(shadow_x[i-1]))
            * longint'(int'(shadow_y[i]) - int'(shadow_y[i-1]));
      sum = longint'(shadow_y[i-1]) + num / dx;
      if (sum > 32767) sum = 32767;
      if (sum < -32768) sum = -32768;
      return sum[Y_W-1:0];
   endfunction

   // Clock.
   initial begin
      forever #2 clock = ~clock;
   end

   // Driver: presents queued words with random gaps and applies each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            if (req_kind == KIND_LOAD) begin
               shadow_x[req_point_index] = req_point_x;
               shadow_y[req_point_index] = req_point_y;
            end else begin
               expected_values.push_back(interpolate_curve(req_query_x));
            end
            void'(pending_words.pop_front());
            if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
            gap_left = burst_mode ? 0 : $urandom_range(0, 19);
         end
         if (start && !fire) begin
            // Hold the current word until it is taken.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_kind        <= pending_words[0].kind;
            req_point_index <= pending_words[0].slot;
            req_point_x     <= pending_words[0].px;
            req_point_y     <= pending_words[0].py;
            req_query_x     <= pending_words[0].qx;
            start           <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compares each result strobe with the oldest expected value.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_values.size() == 0) begin
            unmatched_count++;
            if (mismatch_count + unmatched_count <= 10)
               $display("unexpected result word curve_value=%0d", rsp_curve_value);
         end else begin
            if (rsp_curve_value !== expected_values[0]) begin
               mismatch_count++;
               if (mismatch_count + unmatched_count <= 10)
                  $display("curve_value mismatch: expected %0d, got %0d",
                           expected_values[0], rsp_curve_value);
            end
            void'(expected_values.pop_front());
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[piecewise_linear_curve_lookup_core] ERROR");
         $finish;
      end
   end

   // Waits until every word is taken, every result is in, and the pipe has drained.
   task automatic wait_drained();
      while (pending_words.size() != 0 || start || expected_values.size() != 0)
         @(negedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Writes the point count through the register channel while the block is idle.
   task automatic set_point_count(logic [CNT_W-1:0] count);
      wait_drained();
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_points_in_use <= count;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_count = count;
      @(negedge clock);
   endtask

   task automatic queue_load(int slot, logic [X_W-1:0] x, logic signed [Y_W-1:0] y);
      curve_word_type w;
      w.kind = KIND_LOAD;
      w.slot = slot[IDX_W-1:0];
      w.px   = x;
      w.py   = y;
      w.qx   = X_W'($urandom_range(0, 65535));
      pending_words.push_back(w);
      plan_x[slot] = x;
      words_queued++;
   endtask

   task automatic queue_eval(logic [X_W-1:0] q);
      curve_word_type w;
      w.kind = KIND_EVAL;
      w.slot = IDX_W'($urandom_range(0, DEPTH - 1));
      w.px   = X_W'($urandom_range(0, 65535));
      w.py   = Y_W'($urandom_range(0, 65535));
      w.qx   = q;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Loads a strictly rising table with random spacing and ordinates, slots in random order.
   task automatic load_sorted_table();
      logic [X_W-1:0]        xs [DEPTH];
      logic signed [Y_W-1:0] ys [DEPTH];
      int                    order [DEPTH];
      int                    x;
      int                    max_step;
      int                    j;
      int                    t;
      max_step = ($urandom_range(0, 3) == 0) ? 3 : 4095;
      x = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) x = 0;
      for (int k = 0; k < DEPTH; k++) begin
         xs[k] = x[X_W-1:0];
         ys[k] = Y_W'($urandom_range(0, 65535));
         if ($urandom_range(0, 5) == 0) ys[k] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
         x += $urandom_range(1, max_step);
         order[k] = k;
      end
      if (max_step > 3 && $urandom_range(0, 3) == 0) xs[DEPTH-1] = 16'hFFFF;
      for (int k = DEPTH - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = order[k]; order[k] = order[j]; order[j] = t;
      end
      for (int k = 0; k < DEPTH; k++) queue_load(order[k], xs[order[k]], ys[order[k]]);
   endtask

   // Picks a query aimed at the table: on, next to, or between breakpoints, or anywhere.
   function automatic logic [X_W-1:0] pick_query();
      int s;
      s = $urandom_range(0, DEPTH - 1);
      case ($urandom_range(0, 5))
         0: return plan_x[s];
         1: return plan_x[s] + 16'd1;
         2: return plan_x[s] - 16'd1;
         3: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
         4: return X_W'($urandom_range(0, 65535));
         default: return X_W'($urandom_range(plan_x[0], plan_x[DEPTH-1]));
      endcase
   endfunction

   // Stimulus.
   initial begin
      int count;
      int n_evals;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty curve, then a full table swinging between the ordinate extremes.
      set_point_count(5'd0);
      queue_eval(16'h0000);
      queue_eval(16'hFFFF);
      for (int k = DEPTH - 1; k >= 0; k--)
         queue_load(k, 16'(k * 4369), (k % 2 == 0) ? 16'sh8000 : 16'sh7FFF);
      set_point_count(5'd16);
      queue_eval(16'h0000);
      queue_eval(16'hFFFF);
      queue_eval(16'd4368);
      queue_eval(16'd4370);
      queue_eval(16'd30000);

      // Random phases, the count extremes among them.
      while (words_queued < 530) begin
         case ($urandom_range(0, 7))
            0: count = 0;
            1: count = 1;
            2: count = 2;
            3: count = 16;
            4: count = 31;
            default: count = $urandom_range(0, 31);
         endcase
         set_point_count(count[CNT_W-1:0]);
         if ($urandom_range(0, 1) != 0) load_sorted_table();
         n_evals = $urandom_range(15, 40);
         for (int k = 0; k < n_evals; k++) begin
            if ($urandom_range(0, 19) == 0)
               // A stray load that may break the ordering of the table.
               queue_load($urandom_range(0, DEPTH - 1), X_W'($urandom_range(0, 65535)),
                          Y_W'($urandom_range(0, 65535)));
            queue_eval(pick_query());
         end
      end

      wait_drained();
      if (mismatch_count == 0 && unmatched_count == 0 && expected_values.size() == 0) begin
         $display("[piecewise_linear_curve_lookup_core] OK");
      end else begin
         $display("[piecewise_linear_curve_lookup_core] ERROR");
      end
      $finish;
   end

endmodule
